FILE: hdl/lrk_pkg.sv
// ----------------------------------------------------------------------------
// lrk_pkg: shared types and constants for the longest run with k replacements
// Field widths, default sizes and the result beat type.
// ----------------------------------------------------------------------------
`default_nettype none

package lrk_pkg;

  // Fixed payload widths
  localparam int SYM_W  = 5;
  localparam int K_W    = 13;
  localparam int BEST_W = 13;

  // Default sizes, handed to the top level as parameter defaults
  localparam int MAX_LEN_DEF  = 4096;
  localparam int ALPHABET_DEF = 26;

  // Result queue depth (power of two)
  localparam int OQ_DEPTH = 4;

  typedef struct packed {
    logic [BEST_W-1:0] best_len;
    logic              overflow;
  } lrk_res_t;

endpackage

`default_nettype wire

FILE: hdl/lrk_ifs.sv
// ----------------------------------------------------------------------------
// lrk_ifs: valid/ready channels of the run length block
// Symbol channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrk_in_if
  import lrk_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             first;

  modport source (output valid, output symbol, output first, input ready);
  modport sink (input valid, input symbol, input first, output ready);
endinterface

interface lrk_out_if
  import lrk_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BEST_W-1:0] best_len;
  logic              overflow;

  modport source (output valid, output best_len, output overflow, input ready);
  modport sink (input valid, input best_len, input overflow, output ready);
endinterface

`default_nettype wire

FILE: hdl/lrk_ram.sv
// ----------------------------------------------------------------------------
// lrk_ram: generic single-write, single-read memory
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lrk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/longest_run_with_k_replacements.sv
// ----------------------------------------------------------------------------
// longest_run_with_k_replacements: sliding window over a symbol stream
// Reports, per symbol, the longest window so far that k replacements make
// uniform.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   : one beat per symbol (symbol 0..ALPHABET-1, first marks the start
//             of a new string and clears all per-string state).
//   out_ch  : exactly one beat per input beat, in order: best_len so far and
//             overflow (set when the string already held MAX_LEN symbols and
//             this symbol was dropped).
//   cfg_we / cfg_wdata : write max_changes (k); write only while idle.
// Throughput: one symbol per clock while in_ch.ready is high. The per-letter
//   counts sit in two small memories (occurrences added, occurrences
//   dropped) that are read in the accept cycle and written back in the cycle
//   after it; a one-entry forward path covers a back-to-back hit on the same
//   letter. The symbol store is read at the next window start every cycle, so
//   the oldest symbol is ready when a drop is needed.
// Result path: the compute stage writes each beat's result into the queue.
// Stall: results wait in a 4-entry queue; in_ch.ready drops only when four
//   beats are in flight, so the input keeps moving while a result waits.
// Reset: synchronous, clears k, the window state, the letter valid bits and
//   the queue. No memory clearing pass; the block takes input right away.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_run_with_k_replacements
  import lrk_pkg::*;
#(
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [K_W-1:0] cfg_wdata,
  lrk_in_if.sink              in_ch,
  lrk_out_if.source           out_ch
);

  localparam int PW  = $clog2(MAX_LEN + 1);              // position / count width
  localparam int AW  = $clog2(MAX_LEN);                  // store address width
  localparam int LW  = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int SW  = ((PW > K_W) ? PW : K_W) + 1;      // window limit compare width
  localparam int STW = PW + LW;                          // store entry: ordinal, letter
  localparam int QW  = $clog2(OQ_DEPTH);

  // Configuration
  logic [K_W-1:0] k_r;

  // Accept / compute stage
  logic             in_fire;
  logic             b_vld_r;
  logic             b_first_r;
  logic [SYM_W-1:0] b_sym_r;

  // Window state
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] ws_r, ws_nxt;
  logic [PW-1:0] top_r, top_nxt;
  logic [PW-1:0] best_r, best_nxt;
  logic [ALPHABET-1:0] inc_vld_r, inc_vld_nxt;
  logic [ALPHABET-1:0] dec_vld_r, dec_vld_nxt;

  // Last write of each count memory, for read-during-write forwarding
  logic          inc_lw_we_r, dec_lw_we_r;
  logic [LW-1:0] inc_lw_addr_r, dec_lw_addr_r;
  logic [PW-1:0] inc_lw_data_r, dec_lw_data_r;
  logic           st_fwd_r;
  logic [STW-1:0] st_fwd_data_r;

  // Memory ports
  logic           inc_we, dec_we, st_we;
  logic [LW-1:0]  inc_waddr, dec_waddr, cnt_raddr;
  logic [PW-1:0]  inc_wdata, dec_wdata, inc_rdata, dec_rdata;
  logic [AW-1:0]  st_waddr, st_raddr;
  logic [STW-1:0] st_wdata, st_rdata;

  // Compute stage working values
  logic           first_c, ovf_c, sym_ok, act, drop;
  logic [LW-1:0]  sym_i, old_sym;
  logic [PW-1:0]  pos_c, ws_c, top_c, best_c;
  logic [PW-1:0]  inc_rd, dec_rd, cnt, top1, len, len_f, old_ord;
  logic [STW-1:0] head;
  lrk_res_t       res;

  // Result queue
  lrk_res_t      oq_mem [OQ_DEPTH];
  logic [QW-1:0] oq_wr_r, oq_rd_r;
  logic [QW:0]   oq_cnt_r;
  logic [QW:0]   inflight_r;
  logic          oq_pop;

  // --------------------------------------------------------------------------
  // Input side: accept while fewer than OQ_DEPTH beats are in flight
  // --------------------------------------------------------------------------
  assign in_ch.ready = (inflight_r < (QW + 1)'(OQ_DEPTH));
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Read the letter's counts in the accept cycle; an illegal code reads row 0
  assign cnt_raddr = (int'(in_ch.symbol) < ALPHABET) ? LW'(in_ch.symbol) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (cfg_we) begin
      k_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= in_fire;
    end
    b_sym_r   <= in_ch.symbol;
    b_first_r <= in_ch.first;
  end

  // --------------------------------------------------------------------------
  // Count and symbol memories
  // --------------------------------------------------------------------------
  lrk_ram #(.WIDTH(PW), .DEPTH(ALPHABET)) u_inc_ram (
    .clk   (clk),
    .we    (inc_we),
    .waddr (inc_waddr),
    .wdata (inc_wdata),
    .raddr (cnt_raddr),
    .rdata (inc_rdata)
  );

  lrk_ram #(.WIDTH(PW), .DEPTH(ALPHABET)) u_dec_ram (
    .clk   (clk),
    .we    (dec_we),
    .waddr (dec_waddr),
    .wdata (dec_wdata),
    .raddr (cnt_raddr),
    .rdata (dec_rdata)
  );

  lrk_ram #(.WIDTH(STW), .DEPTH(MAX_LEN)) u_sym_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // --------------------------------------------------------------------------
  // Compute stage: modify counts, slide the window, write back
  // --------------------------------------------------------------------------
  always_comb begin
    // A new string sees all state cleared
    first_c = b_vld_r && b_first_r;
    pos_c   = first_c ? '0 : pos_r;
    ws_c    = first_c ? '0 : ws_r;
    top_c   = first_c ? '0 : top_r;
    best_c  = first_c ? '0 : best_r;

    ovf_c  = b_vld_r && (pos_c == PW'(MAX_LEN));
    sym_ok = int'(b_sym_r) < ALPHABET;
    act    = b_vld_r && !ovf_c && sym_ok;
    sym_i  = LW'(b_sym_r);

    // Occurrences added / dropped for this letter; forward last cycle's write
    if (first_c) begin
      inc_rd = '0;
    end else if (inc_lw_we_r && (inc_lw_addr_r == sym_i)) begin
      inc_rd = inc_lw_data_r;
    end else if (inc_vld_r[sym_i]) begin
      inc_rd = inc_rdata;
    end else begin
      inc_rd = '0;
    end

    if (first_c) begin
      dec_rd = '0;
    end else if (dec_lw_we_r && (dec_lw_addr_r == sym_i)) begin
      dec_rd = dec_lw_data_r;
    end else if (dec_vld_r[sym_i]) begin
      dec_rd = dec_rdata;
    end else begin
      dec_rd = '0;
    end

    cnt  = inc_rd + PW'(1) - dec_rd;
    top1 = (cnt > top_c) ? cnt : top_c;
    len  = pos_c - ws_c + PW'(1);
    drop = act && (SW'(len) > (SW'(top1) + SW'(k_r)));

    // Oldest symbol of the window, read last cycle at the current start
    head    = st_fwd_r ? st_fwd_data_r : st_rdata;
    old_sym = head[LW-1:0];
    old_ord = head[STW-1:LW];
    len_f   = len - PW'(drop);

    top_nxt  = top_c;
    ws_nxt   = ws_c;
    pos_nxt  = pos_c;
    best_nxt = best_c;
    if (act) begin
      top_nxt  = top1;
      ws_nxt   = ws_c + PW'(drop);
      pos_nxt  = pos_c + PW'(1);
      best_nxt = (len_f > best_c) ? len_f : best_c;
    end

    inc_we    = act;
    inc_waddr = sym_i;
    inc_wdata = inc_rd + PW'(1);

    // Drops go in order, so the dropped count becomes the ordinal plus one
    dec_we    = drop;
    dec_waddr = old_sym;
    dec_wdata = old_ord + PW'(1);

    st_we    = act;
    st_waddr = AW'(pos_c);
    st_wdata = {inc_rd, sym_i};
    st_raddr = AW'(ws_nxt);

    inc_vld_nxt = first_c ? '0 : inc_vld_r;
    dec_vld_nxt = first_c ? '0 : dec_vld_r;
    if (inc_we) begin
      inc_vld_nxt[sym_i] = 1'b1;
    end
    if (dec_we) begin
      dec_vld_nxt[old_sym] = 1'b1;
    end

    res.best_len = BEST_W'(best_nxt);
    res.overflow = ovf_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      ws_r        <= '0;
      top_r       <= '0;
      best_r      <= '0;
      inc_vld_r   <= '0;
      dec_vld_r   <= '0;
      inc_lw_we_r <= 1'b0;
      dec_lw_we_r <= 1'b0;
      st_fwd_r    <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      ws_r        <= ws_nxt;
      top_r       <= top_nxt;
      best_r      <= best_nxt;
      inc_vld_r   <= inc_vld_nxt;
      dec_vld_r   <= dec_vld_nxt;
      inc_lw_we_r <= inc_we;
      dec_lw_we_r <= dec_we;
      st_fwd_r    <= st_we && (st_waddr == st_raddr);
    end
    inc_lw_addr_r <= inc_waddr;
    inc_lw_data_r <= inc_wdata;
    dec_lw_addr_r <= dec_waddr;
    dec_lw_data_r <= dec_wdata;
    st_fwd_data_r <= st_wdata;
  end

  // --------------------------------------------------------------------------
  // Result queue: push every computed beat, pop on the output handshake
  // --------------------------------------------------------------------------
  assign oq_pop          = out_ch.valid && out_ch.ready;
  assign out_ch.valid    = (oq_cnt_r != '0);
  assign out_ch.best_len = oq_mem[oq_rd_r].best_len;
  assign out_ch.overflow = oq_mem[oq_rd_r].overflow;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r    <= '0;
      oq_rd_r    <= '0;
      oq_cnt_r   <= '0;
      inflight_r <= '0;
    end else begin
      if (b_vld_r) begin
        oq_wr_r <= oq_wr_r + QW'(1);
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + QW'(1);
      end
      oq_cnt_r   <= oq_cnt_r + (QW + 1)'(b_vld_r) - (QW + 1)'(oq_pop);
      inflight_r <= inflight_r + (QW + 1)'(in_fire) - (QW + 1)'(oq_pop);
    end
    if (b_vld_r) begin
      oq_mem[oq_wr_r] <= res;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= (QW + 1)'(OQ_DEPTH))
    else $error("more beats in flight than the result queue holds");

  a_queue_vs_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    (QW + 1)'(b_vld_r) + oq_cnt_r == inflight_r)
    else $error("in-flight count out of step with stage and queue");

  a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
    (ws_r <= pos_r) && (pos_r <= PW'(MAX_LEN)))
    else $error("window start past position or position past limit");

  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (top_r <= pos_r) && (best_r <= pos_r))
    else $error("letter or window length exceeds string length");

  a_one_result_per_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> b_vld_r)
    else $error("accepted beat did not reach the compute stage");

endmodule

`default_nettype wire
